>>> hw/rtl/ddzb_pkg.sv
// ----------------------------------------------------------------------------
// ddzb_pkg
// Shared types, constants and helpers of the delta/zigzag bit-pack encoder.
// ----------------------------------------------------------------------------
package ddzb_pkg;

    localparam int BLOCK_ROWS_DEF     = 8;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int RUN_COUNT_BITS_DEF = 8;

    localparam int CHANNELS = 3;
    localparam int SAMPLE_W = 16;
    localparam int WIDTH_W  = 5;
    localparam int RUN_W    = 8;

    typedef logic [WIDTH_W-1:0] width_t;

    typedef enum logic [1:0] {
        KIND_RUN = 2'd0,
        KIND_HDR = 2'd1,
        KIND_ROW = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RUN,
        ST_HDR,
        ST_ROW
    } state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_ch0;
        logic [SAMPLE_W-1:0] sample_ch1;
        logic [SAMPLE_W-1:0] sample_ch2;
    } sample_t;

    typedef struct packed {
        kind_t               kind;
        width_t              width_ch0;
        width_t              width_ch1;
        width_t              width_ch2;
        logic [SAMPLE_W-1:0] code_ch0;
        logic [SAMPLE_W-1:0] code_ch1;
        logic [SAMPLE_W-1:0] code_ch2;
        logic [RUN_W-1:0]    run_length;
        logic                last;
    } result_t;

    // number of significant bits, zero for an all-zero value
    function automatic width_t bit_width(logic [SAMPLE_W-1:0] v);
        width_t w;
        w = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (v[i])
            begin
                w = WIDTH_W'(i + 1);
            end
        end
        return w;
    endfunction

endpackage

>>> hw/rtl/ddzb_ram.sv
// ----------------------------------------------------------------------------
// ddzb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ddzb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ddzb_front.sv
// ----------------------------------------------------------------------------
// ddzb_front
// Second-order residual, zigzag code, OR accumulation and row counter.
// ----------------------------------------------------------------------------
module ddzb_front #(
    parameter int BLOCK_ROWS  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ddzb_pkg::sample_t               sample,
    input  logic                            accept,
    input  logic                            clear_acc,
    output logic [$clog2(BLOCK_ROWS)-1:0]   row,
    output logic                            row_last,
    output logic [3*SAMPLE_BITS-1:0]        row_data,
    output logic [3*SAMPLE_BITS-1:0]        acc
);
    import ddzb_pkg::*;

    localparam int ROW_BITS = $clog2(BLOCK_ROWS);

    logic [SAMPLE_BITS-1:0] smp        [CHANNELS];
    logic [SAMPLE_BITS-1:0] resid      [CHANNELS];
    logic [SAMPLE_BITS-1:0] code       [CHANNELS];
    logic [SAMPLE_BITS-1:0] older_reg  [CHANNELS];
    logic [SAMPLE_BITS-1:0] older_next [CHANNELS];
    logic [SAMPLE_BITS-1:0] newer_reg  [CHANNELS];
    logic [SAMPLE_BITS-1:0] newer_next [CHANNELS];
    logic [SAMPLE_BITS-1:0] acc_reg    [CHANNELS];
    logic [SAMPLE_BITS-1:0] acc_next   [CHANNELS];
    logic [ROW_BITS-1:0]    row_reg;
    logic [ROW_BITS-1:0]    row_next;

    assign smp[0] = SAMPLE_BITS'(sample.sample_ch0);
    assign smp[1] = SAMPLE_BITS'(sample.sample_ch1);
    assign smp[2] = SAMPLE_BITS'(sample.sample_ch2);

    assign row      = row_reg;
    assign row_last = (row_reg == ROW_BITS'(BLOCK_ROWS - 1));

    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            resid[k] = {newer_reg[k][SAMPLE_BITS-2:0], 1'b0} - older_reg[k] - smp[k];
            code[k]  = {resid[k][SAMPLE_BITS-2:0], 1'b0} ^ {SAMPLE_BITS{resid[k][SAMPLE_BITS-1]}};
            row_data[k*SAMPLE_BITS +: SAMPLE_BITS] = code[k];
            acc[k*SAMPLE_BITS +: SAMPLE_BITS]      = acc_reg[k];
            older_next[k] = accept ? newer_reg[k] : older_reg[k];
            newer_next[k] = accept ? smp[k] : newer_reg[k];
            if (clear_acc)
            begin
                acc_next[k] = '0;
            end
            else if (accept)
            begin
                acc_next[k] = acc_reg[k] | code[k];
            end
            else
            begin
                acc_next[k] = acc_reg[k];
            end
        end
        if (accept)
        begin
            row_next = row_last ? '0 : row_reg + 1'b1;
        end
        else
        begin
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                older_reg[k] <= '0;
                newer_reg[k] <= '0;
                acc_reg[k]   <= '0;
            end
            row_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                older_reg[k] <= older_next[k];
                newer_reg[k] <= newer_next[k];
                acc_reg[k]   <= acc_next[k];
            end
            row_reg <= row_next;
        end
    end

endmodule

>>> hw/rtl/ddzb_emit.sv
// ----------------------------------------------------------------------------
// ddzb_emit
// Block evaluation, zero-run counting and result sequencing from the row RAM.
// ----------------------------------------------------------------------------
module ddzb_emit #(
    parameter int BLOCK_ROWS     = 8,
    parameter int SAMPLE_BITS    = 16,
    parameter int RUN_COUNT_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          block_end,
    input  logic [3*SAMPLE_BITS-1:0]      acc,
    input  logic [3*SAMPLE_BITS-1:0]      rdata,
    output logic                          clear_acc,
    output logic                          ram_re,
    output logic [$clog2(BLOCK_ROWS)-1:0] ram_raddr,
    output logic                          sample_ready,
    output ddzb_pkg::result_t             result,
    output logic                          result_valid,
    input  logic                          result_ready
);
    import ddzb_pkg::*;

    localparam int ROW_BITS = $clog2(BLOCK_ROWS);
    localparam logic [ROW_BITS-1:0]       LAST_ROW = ROW_BITS'(BLOCK_ROWS - 1);
    localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX  = {RUN_COUNT_BITS{1'b1}};

    state_t                    state_reg, state_next;
    width_t                    widths_reg  [CHANNELS];
    width_t                    widths_next [CHANNELS];
    width_t                    widths_eval [CHANNELS];
    logic                      eval_zero;
    logic                      widths_zero;
    logic [RUN_COUNT_BITS-1:0] run_reg, run_next, run_inc;
    logic [ROW_BITS-1:0]       idx_reg, idx_next;
    result_t                   out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_free;

    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            widths_eval[k] = bit_width(SAMPLE_W'(acc[k*SAMPLE_BITS +: SAMPLE_BITS]));
        end
    end

    assign eval_zero   = (widths_eval[0] == '0) && (widths_eval[1] == '0)
                         && (widths_eval[2] == '0);
    assign widths_zero = (widths_reg[0] == '0) && (widths_reg[1] == '0)
                         && (widths_reg[2] == '0);
    assign run_inc     = run_reg + 1'b1;
    assign out_free    = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (block_end)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (eval_zero)
                begin
                    state_next = (run_inc == RUN_MAX) ? ST_RUN : ST_IDLE;
                end
                else
                begin
                    state_next = (run_reg != '0) ? ST_RUN : ST_HDR;
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    state_next = widths_zero ? ST_IDLE : ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (out_free)
                begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                if (out_free && (idx_reg == LAST_ROW))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        widths_next    = widths_reg;
        run_next       = run_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;
        clear_acc      = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg;
        sample_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
            end
            ST_EVAL:
            begin
                clear_acc   = 1'b1;
                widths_next = widths_eval;
                if (eval_zero)
                begin
                    run_next = run_inc;
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    out_next            = '0;
                    out_next.kind       = KIND_RUN;
                    out_next.run_length = RUN_W'(run_reg);
                    out_next.last       = widths_zero;
                    out_valid_next      = 1'b1;
                    run_next            = '0;
                end
            end
            ST_HDR:
            begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                if (out_free)
                begin
                    out_next           = '0;
                    out_next.kind      = KIND_HDR;
                    out_next.width_ch0 = widths_reg[0];
                    out_next.width_ch1 = widths_reg[1];
                    out_next.width_ch2 = widths_reg[2];
                    out_valid_next     = 1'b1;
                    idx_next           = '0;
                end
            end
            ST_ROW:
            begin
                if (out_free)
                begin
                    out_next           = '0;
                    out_next.kind      = KIND_ROW;
                    out_next.width_ch0 = widths_reg[0];
                    out_next.width_ch1 = widths_reg[1];
                    out_next.width_ch2 = widths_reg[2];
                    out_next.code_ch0  = SAMPLE_W'(rdata[0*SAMPLE_BITS +: SAMPLE_BITS]);
                    out_next.code_ch1  = SAMPLE_W'(rdata[1*SAMPLE_BITS +: SAMPLE_BITS]);
                    out_next.code_ch2  = SAMPLE_W'(rdata[2*SAMPLE_BITS +: SAMPLE_BITS]);
                    out_next.last      = (idx_reg == LAST_ROW);
                    out_valid_next     = 1'b1;
                    if (idx_reg != LAST_ROW)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + 1'b1;
                        idx_next  = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        widths_reg <= widths_next;
        idx_reg    <= idx_next;
        out_reg    <= out_next;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

>>> hw/rtl/delta_zigzag_bitpack_encoder.sv
// ----------------------------------------------------------------------------
// delta_zigzag_bitpack_encoder
// Three-channel second-order delta, zigzag and block bit-width encoder with
// zero-block run tokens.
// ----------------------------------------------------------------------------
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------
//   sample   | sample_valid / sample_ready  | sample_t: three samples
//   result   | result_valid / result_ready  | result_t: run, header or row
//
// Mid-block samples are taken only while the emitter is idle. The last sample
// of a block is followed by an evaluation state, then one result per cycle,
// while result_ready allows, through the single result register and the one
// read port of the row RAM: up to BLOCK_ROWS + 2 results per block.
// Reset clears sample history, OR accumulators, row and run counters; the
// row RAM is not cleared. A low result_ready holds the result sequence.
// ----------------------------------------------------------------------------
module delta_zigzag_bitpack_encoder #(
    parameter int BLOCK_ROWS     = ddzb_pkg::BLOCK_ROWS_DEF,
    parameter int SAMPLE_BITS    = ddzb_pkg::SAMPLE_BITS_DEF,
    parameter int RUN_COUNT_BITS = ddzb_pkg::RUN_COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  ddzb_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output ddzb_pkg::result_t result
);
    import ddzb_pkg::*;

    localparam int ROW_BITS = $clog2(BLOCK_ROWS);
    localparam int ROW_W    = CHANNELS * SAMPLE_BITS;

    logic                accept;
    logic                block_end;
    logic                clear_acc;
    logic [ROW_BITS-1:0] row;
    logic                row_last;
    logic [ROW_W-1:0]    row_data;
    logic [ROW_W-1:0]    acc;
    logic                ram_re;
    logic [ROW_BITS-1:0] ram_raddr;
    logic [ROW_W-1:0]    ram_rdata;

    assign accept    = sample_valid && sample_ready;
    assign block_end = accept && row_last;

    ddzb_front #(
        .BLOCK_ROWS  (BLOCK_ROWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .accept    (accept),
        .clear_acc (clear_acc),
        .row       (row),
        .row_last  (row_last),
        .row_data  (row_data),
        .acc       (acc)
    );

    ddzb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BLOCK_ROWS)
    ) u_rows (
        .clk   (clk),
        .we    (accept),
        .waddr (row),
        .wdata (row_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ddzb_emit #(
        .BLOCK_ROWS     (BLOCK_ROWS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .RUN_COUNT_BITS (RUN_COUNT_BITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .block_end    (block_end),
        .acc          (acc),
        .rdata        (ram_rdata),
        .clear_acc    (clear_acc),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .sample_ready (sample_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_RUN) |-> (result.run_length != '0))
        else $error("run token with zero count");

    a_hdr_width: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_HDR)
        |-> (result.width_ch0 != '0 || result.width_ch1 != '0 || result.width_ch2 != '0))
        else $error("header for an all-zero block");

    a_row_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && result.kind == KIND_ROW && !result.last)
        |=> (!result_valid || result.kind == KIND_ROW))
        else $error("payload rows interrupted");

endmodule
